// ----- hdl/vgin_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package vgin_pkg;

  // Default grid side, cells per axis.
  localparam int GRID_SIDE_DEF = 32;

  // Field widths.
  localparam int POS_W      = 8;
  localparam int SPAN_W     = 6;
  localparam int RAD_W      = 5;
  localparam int SZ_W       = 6;
  localparam int INF_W      = 4;
  localparam int OUT_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  // Signed working width for coordinates, bounds and offsets. Covers
  // corner + span + inflation and every grid side up to 256.
  localparam int CRD_W = 10;
  // Signed shell offset width (-31..31).
  localparam int DLT_W = 6;

  // Operation codes.
  localparam logic OP_STAMP = 1'b0;
  localparam logic OP_NUDGE = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INFLATE = 2'd3;

  // Register reset values.
  localparam logic [SZ_W-1:0]  SIZE_RST    = 6'd32;
  localparam logic [INF_W-1:0] INFLATE_RST = 4'd0;

  typedef struct packed {
    logic                    operation;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [SPAN_W-1:0]       span;
    logic [RAD_W-1:0]        search_radius;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [OUT_W-1:0] free_x;
    logic [OUT_W-1:0] free_y;
    logic [OUT_W-1:0] free_z;
  } out_item_t;

  typedef struct packed {
    logic [SZ_W-1:0]  size_x;
    logic [SZ_W-1:0]  size_y;
    logic [SZ_W-1:0]  size_z;
    logic [INF_W-1:0] inflate_cells;
  } cfg_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic clr_step;
    logic st_setup;
    logic st_step;
    logic nd_step;
    logic nd_fin;
    logic out_load;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clr_last;
    logic st_empty;
    logic st_last;
    logic nd_done;
    logic out_free;
  } sts_t;

  // Square of a 4-bit gap.
  function automatic logic [7:0] sq4(input logic [INF_W-1:0] v);
    logic [7:0] s;
    case (v)
      4'd0:    s = 8'd0;
      4'd1:    s = 8'd1;
      4'd2:    s = 8'd4;
      4'd3:    s = 8'd9;
      4'd4:    s = 8'd16;
      4'd5:    s = 8'd25;
      4'd6:    s = 8'd36;
      4'd7:    s = 8'd49;
      4'd8:    s = 8'd64;
      4'd9:    s = 8'd81;
      4'd10:   s = 8'd100;
      4'd11:   s = 8'd121;
      4'd12:   s = 8'd144;
      4'd13:   s = 8'd169;
      4'd14:   s = 8'd196;
      4'd15:   s = 8'd225;
      default: s = 8'd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/vgin_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module vgin_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_op,
  output logic               in_stall,
  output vgin_pkg::cmd_t     cmd,
  input  wire vgin_pkg::sts_t sts
);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_SETUP  = 6'b000100,
    S_STAMP  = 6'b001000,
    S_NUDGE  = 6'b010000,
    S_RESULT = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = (in_op == vgin_pkg::OP_STAMP) ? S_SETUP : S_NUDGE;
        end
      end
      S_SETUP: begin
        cmd.st_setup = 1'b1;
        state_nxt    = sts.st_empty ? S_IDLE : S_STAMP;
      end
      S_STAMP: begin
        cmd.st_step = 1'b1;
        if (sts.st_last) state_nxt = S_IDLE;
      end
      S_NUDGE: begin
        cmd.nd_step = 1'b1;
        if (sts.nd_done) begin
          cmd.nd_fin = 1'b1;
          state_nxt  = S_RESULT;
        end
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A search leaves only once it has settled.
  a_nudge_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_NUDGE && !sts.nd_done) |=> (state_r == S_NUDGE))
    else $error("nudge search left early");

  // A finished result waits until the output register is free.
  a_result_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESULT && !sts.out_free) |=> (state_r == S_RESULT))
    else $error("result dropped while output busy");

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("controller state not one-hot");

endmodule

`default_nettype wire

// ----- hdl/vgin_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module vgin_dp #(
  parameter int GRID_SIDE = vgin_pkg::GRID_SIDE_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire vgin_pkg::cfg_t      cfg,
  input  wire vgin_pkg::in_item_t  in_data,
  input  wire vgin_pkg::cmd_t      cmd,
  output vgin_pkg::sts_t           sts,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output vgin_pkg::out_item_t      out_data
);

  localparam int CW    = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
  localparam int AW    = 3 * CW;
  localparam int DEPTH = 1 << AW;
  localparam int CRD_W = vgin_pkg::CRD_W;
  localparam int DLT_W = vgin_pkg::DLT_W;
  localparam int RAD_W = vgin_pkg::RAD_W;
  localparam int OUT_W = vgin_pkg::OUT_W;

  localparam logic signed [CRD_W-1:0] GS_C   = CRD_W'(GRID_SIDE);
  localparam logic signed [CRD_W-1:0] ZERO_C = '0;
  localparam logic signed [CRD_W-1:0] ONE_C  = CRD_W'(1);
  localparam logic signed [DLT_W-1:0] DONE_C = DLT_W'(1);
  localparam logic [RAD_W-1:0]        RONE_C = RAD_W'(1);

  // Distance from c to the interval [lo, hi]; callers keep it below 16.
  function automatic logic [vgin_pkg::INF_W-1:0] gap4(
    input logic signed [CRD_W-1:0] c,
    input logic signed [CRD_W-1:0] lo,
    input logic signed [CRD_W-1:0] hi
  );
    logic signed [CRD_W-1:0] g;
    if (c < lo)      g = lo - c;
    else if (c > hi) g = c - hi;
    else             g = ZERO_C;
    return g[vgin_pkg::INF_W-1:0];
  endfunction

  function automatic logic signed [CRD_W-1:0] eff_size(input logic [vgin_pkg::SZ_W-1:0] s);
    logic signed [CRD_W-1:0] e;
    e = signed'({{(CRD_W - vgin_pkg::SZ_W){1'b0}}, s});
    return (e > GS_C) ? GS_C : e;
  endfunction

  // ---- item and common values ----
  vgin_pkg::in_item_t itm_r;

  logic signed [CRD_W-1:0] px_s, py_s, pz_s, span_s, inf_s;
  logic signed [CRD_W-1:0] effx, effy, effz;
  logic [7:0]              inf_sq;

  assign px_s   = signed'({{(CRD_W - vgin_pkg::POS_W){itm_r.pos_x[vgin_pkg::POS_W-1]}},
                           itm_r.pos_x});
  assign py_s   = signed'({{(CRD_W - vgin_pkg::POS_W){itm_r.pos_y[vgin_pkg::POS_W-1]}},
                           itm_r.pos_y});
  assign pz_s   = signed'({{(CRD_W - vgin_pkg::POS_W){itm_r.pos_z[vgin_pkg::POS_W-1]}},
                           itm_r.pos_z});
  assign span_s = signed'({{(CRD_W - vgin_pkg::SPAN_W){1'b0}}, itm_r.span});
  assign inf_s  = signed'({{(CRD_W - vgin_pkg::INF_W){1'b0}}, cfg.inflate_cells});
  assign effx   = eff_size(cfg.size_x);
  assign effy   = eff_size(cfg.size_y);
  assign effz   = eff_size(cfg.size_z);
  assign inf_sq = vgin_pkg::sq4(cfg.inflate_cells);

  always_ff @(posedge clk) begin
    if (cmd.load) itm_r <= in_data;
  end

  // ---- stamp setup: clipped scan box ----
  logic signed [CRD_W-1:0] hbx, hby, hbz;
  logic signed [CRD_W-1:0] lox, loy, loz, hix, hiy, hiz;
  logic signed [CRD_W-1:0] a0x, a0y, a0z, a1x, a1y, a1z;

  assign hbx = px_s + span_s - ONE_C;
  assign hby = py_s + span_s - ONE_C;
  assign hbz = pz_s + span_s - ONE_C;
  assign lox = px_s - inf_s;
  assign loy = py_s - inf_s;
  assign loz = pz_s - inf_s;
  assign hix = hbx + inf_s;
  assign hiy = hby + inf_s;
  assign hiz = hbz + inf_s;
  assign a0x = (lox < ZERO_C) ? ZERO_C : lox;
  assign a0y = (loy < ZERO_C) ? ZERO_C : loy;
  assign a0z = (loz < ZERO_C) ? ZERO_C : loz;
  assign a1x = (hix > effx - ONE_C) ? effx - ONE_C : hix;
  assign a1y = (hiy > effy - ONE_C) ? effy - ONE_C : hiy;
  assign a1z = (hiz > effz - ONE_C) ? effz - ONE_C : hiz;

  assign sts.st_empty = (itm_r.span == '0) || (a0x > a1x) || (a0y > a1y) || (a0z > a1z);

  logic [CW-1:0]           x0_r, x1_r, y0_r, y1_r, z0_r, z1_r;
  logic [CW-1:0]           x_r, y_r, z_r;
  logic signed [CRD_W-1:0] hbx_r, hby_r, hbz_r;

  // ---- stamp scan ----
  logic signed [CRD_W-1:0] xs, ys, zs;
  logic [9:0]              dist_sq;
  logic                    mark;

  assign xs = signed'(CRD_W'(x_r));
  assign ys = signed'(CRD_W'(y_r));
  assign zs = signed'(CRD_W'(z_r));
  assign dist_sq = 10'(vgin_pkg::sq4(gap4(xs, px_s, hbx_r)))
                 + 10'(vgin_pkg::sq4(gap4(ys, py_s, hby_r)))
                 + 10'(vgin_pkg::sq4(gap4(zs, pz_s, hbz_r)));
  assign mark = dist_sq <= 10'(inf_sq);

  assign sts.st_last = (x_r == x1_r) && (y_r == y1_r) && (z_r == z1_r);

  always_ff @(posedge clk) begin
    if (cmd.st_setup) begin
      x0_r  <= a0x[CW-1:0];
      x1_r  <= a1x[CW-1:0];
      y0_r  <= a0y[CW-1:0];
      y1_r  <= a1y[CW-1:0];
      z0_r  <= a0z[CW-1:0];
      z1_r  <= a1z[CW-1:0];
      x_r   <= a0x[CW-1:0];
      y_r   <= a0y[CW-1:0];
      z_r   <= a0z[CW-1:0];
      hbx_r <= hbx;
      hby_r <= hby;
      hbz_r <= hbz;
    end else if (cmd.st_step) begin
      if (x_r != x1_r) begin
        x_r <= x_r + CW'(1);
      end else begin
        x_r <= x0_r;
        if (y_r != y1_r) begin
          y_r <= y_r + CW'(1);
        end else begin
          y_r <= y0_r;
          z_r <= z_r + CW'(1);
        end
      end
    end
  end

  // ---- clear sweep ----
  logic [AW-1:0] clr_cnt_r;

  assign sts.clr_last = &clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  // ---- shell walker ----
  logic                    wk_act_r;
  logic [RAD_W-1:0]        r_r, r_nxt, r_inc;
  logic signed [DLT_W-1:0] dx_r, dy_r, dz_r, dx_nxt, dy_nxt, dz_nxt;
  logic signed [DLT_W-1:0] rs, nrs, nrs1;
  logic                    face, wk_last;

  assign r_inc   = r_r + RONE_C;
  assign rs      = signed'({1'b0, r_r});
  assign nrs     = -rs;
  assign nrs1    = -signed'({1'b0, r_inc});
  assign face    = (dz_r == rs) || (dz_r == nrs) || (dy_r == rs) || (dy_r == nrs);
  assign wk_last = (dz_r == rs) && (dy_r == rs) && (dx_r == rs) && (r_r == itm_r.search_radius);

  always_comb begin
    dx_nxt = dx_r;
    dy_nxt = dy_r;
    dz_nxt = dz_r;
    r_nxt  = r_r;
    if (dx_r != rs) begin
      // Inside the shell's faces only the two x ends belong to it.
      dx_nxt = face ? dx_r + DONE_C : rs;
    end else begin
      dx_nxt = nrs;
      if (dy_r != rs) begin
        dy_nxt = dy_r + DONE_C;
      end else begin
        dy_nxt = nrs;
        if (dz_r != rs) begin
          dz_nxt = dz_r + DONE_C;
        end else begin
          r_nxt  = r_inc;
          dz_nxt = nrs1;
          dy_nxt = nrs1;
          dx_nxt = nrs1;
        end
      end
    end
  end

  logic signed [CRD_W-1:0] cx, cy, cz;
  logic                    c_inb;
  logic [AW-1:0]           raddr;

  assign cx = px_s + signed'({{(CRD_W - DLT_W){dx_r[DLT_W-1]}}, dx_r});
  assign cy = py_s + signed'({{(CRD_W - DLT_W){dy_r[DLT_W-1]}}, dy_r});
  assign cz = pz_s + signed'({{(CRD_W - DLT_W){dz_r[DLT_W-1]}}, dz_r});
  assign c_inb = (cx >= ZERO_C) && (cy >= ZERO_C) && (cz >= ZERO_C) &&
                 (cx < effx) && (cy < effy) && (cz < effz);
  assign raddr = {cz[CW-1:0], cy[CW-1:0], cx[CW-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wk_act_r <= 1'b0;
    end else if (cmd.load) begin
      wk_act_r <= (in_data.operation == vgin_pkg::OP_NUDGE);
    end else if (cmd.nd_step && wk_act_r && wk_last) begin
      wk_act_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_r  <= '0;
      dx_r <= '0;
      dy_r <= '0;
      dz_r <= '0;
    end else if (cmd.nd_step && wk_act_r) begin
      r_r  <= r_nxt;
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
      dz_r <= dz_nxt;
    end
  end

  // ---- check stage: candidate meets its memory read ----
  logic             vb_r, inbb_r;
  logic [OUT_W-1:0] bx_r, by_r, bz_r;
  logic             hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else begin
      vb_r <= cmd.nd_step && wk_act_r;
    end
  end

  always_ff @(posedge clk) begin
    inbb_r <= c_inb;
    bx_r   <= cx[OUT_W-1:0];
    by_r   <= cy[OUT_W-1:0];
    bz_r   <= cz[OUT_W-1:0];
  end

  // ---- occupancy memory ----
  logic          occ_mem_r [DEPTH];
  logic          rd_r;
  logic          mem_we;
  logic [AW-1:0] waddr;

  assign mem_we = cmd.clr_step || (cmd.st_step && mark);
  assign waddr  = cmd.clr_step ? clr_cnt_r : {z_r, y_r, x_r};

  always_ff @(posedge clk) begin
    if (mem_we) occ_mem_r[waddr] <= cmd.st_step;
    rd_r <= occ_mem_r[raddr];
  end

  assign hit         = vb_r && inbb_r && !rd_r;
  assign sts.nd_done = hit || (!wk_act_r && !vb_r);

  // ---- result and output register ----
  vgin_pkg::out_item_t res_r, out_r;
  logic                out_valid_r;

  always_ff @(posedge clk) begin
    if (cmd.nd_fin) begin
      res_r.found  <= hit;
      res_r.free_x <= hit ? bx_r : '0;
      res_r.free_y <= hit ? by_r : '0;
      res_r.free_z <= hit ? bz_r : '0;
    end
    if (cmd.out_load) out_r <= res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.out_free = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

  a_stamp_in_box: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.st_step |-> (x_r >= x0_r && x_r <= x1_r && y_r >= y0_r && y_r <= y1_r &&
                     z_r >= z0_r && z_r <= z1_r))
    else $error("stamp counter outside its scan box");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("output register overwritten while held");

  a_radius_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wk_act_r |-> (r_r <= itm_r.search_radius))
    else $error("shell walker past search radius");

endmodule

`default_nettype wire

// ----- hdl/voxel_grid_inflate_and_nudge_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Inflated 3-D occupancy grid with nearest-free-voxel search. The grid is a
// one-bit-per-voxel memory of 2^(3*ceil(log2 GRID_SIDE)) entries (32768 at
// the default side of 32), addressed as {z, y, x}. After reset the block
// sweeps that memory to zero, one entry per cycle; no item is taken during
// the sweep, configuration writes are. Items are processed one at a time,
// and every cycle at most one voxel goes through each of the memory's two
// ports, one for writes and one for reads. A stamp first sets up its box,
// widened by the inflation radius and clipped to the grid, then visits each
// voxel of it and marks the voxels within the squared Euclidean radius. A
// nudge walk starts with the query voxel and then covers the surface of each
// Chebyshev shell in dz, dy, dx order, up to (2R+1)^3 voxels for search
// radius R, and stops at the first free in-bounds voxel. A nudge gives
// exactly one result item, a stamp none. The result sits in an output
// register, so the next item is taken while it waits; a second result
// waits for the first to be taken, and the input stalls meanwhile. Write
// configuration only while the block is idle.

module voxel_grid_inflate_and_nudge_core #(
  parameter int GRID_SIDE = vgin_pkg::GRID_SIDE_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire vgin_pkg::in_item_t                  in_data,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output vgin_pkg::out_item_t                      out_data,
  // configuration write port
  input  wire logic                                cfg_we,
  input  wire logic [vgin_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [vgin_pkg::CFG_DATA_W-1:0]     cfg_data
);

  vgin_pkg::cfg_t cfg_r;
  vgin_pkg::cmd_t cmd;
  vgin_pkg::sts_t sts;

  // Configuration registers; hold between writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.size_x        <= vgin_pkg::SIZE_RST;
      cfg_r.size_y        <= vgin_pkg::SIZE_RST;
      cfg_r.size_z        <= vgin_pkg::SIZE_RST;
      cfg_r.inflate_cells <= vgin_pkg::INFLATE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        vgin_pkg::CFG_SIZE_X:  cfg_r.size_x        <= cfg_data[vgin_pkg::SZ_W-1:0];
        vgin_pkg::CFG_SIZE_Y:  cfg_r.size_y        <= cfg_data[vgin_pkg::SZ_W-1:0];
        vgin_pkg::CFG_SIZE_Z:  cfg_r.size_z        <= cfg_data[vgin_pkg::SZ_W-1:0];
        vgin_pkg::CFG_INFLATE: cfg_r.inflate_cells <= cfg_data[vgin_pkg::INF_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: clear sweep, then one item at a time.
  vgin_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.operation),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Grid memory, stamp scanner, shell walker and output register.
  vgin_dp #(
    .GRID_SIDE (GRID_SIDE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
